@@ rtl/wsl_pkg.sv @@
package wsl_pkg;

  localparam int unsigned RPM_W      = 16;
  localparam int unsigned SLIP_W     = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned PROD_W     = 32;

  localparam logic [RPM_W-1:0] SLIP_SCALE = 16'd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GPS_MODE       = 3'd0,
    CFG_TIRE_CIRC      = 3'd1,
    CFG_SECOND_THRESH  = 3'd2,
    CFG_MIN_VEH_RPM    = 3'd3,
    CFG_SLIP_THRESH    = 3'd4,
    CFG_MIN_GPS_SPEED  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              gps_mode;
    logic [RPM_W-1:0]  tire_circumference;
    logic [RPM_W-1:0]  second_speed_threshold;
    logic [RPM_W-1:0]  min_vehicle_rpm;
    logic [SLIP_W-1:0] slip_threshold;
    logic [RPM_W-1:0]  min_gps_speed;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [RPM_W-1:0]  rem_init;
    logic [RPM_W-1:0]  dividend;
    logic [RPM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

@@ rtl/wsl_cfg.sv @@
module wsl_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [wsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wsl_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (wsl_pkg::cfg_idx_t'(cfg_index))
        wsl_pkg::CFG_GPS_MODE:      cfg.gps_mode <= cfg_data[0];
        wsl_pkg::CFG_TIRE_CIRC:     cfg.tire_circumference <= cfg_data;
        wsl_pkg::CFG_SECOND_THRESH: cfg.second_speed_threshold <= cfg_data;
        wsl_pkg::CFG_MIN_VEH_RPM:   cfg.min_vehicle_rpm <= cfg_data;
        wsl_pkg::CFG_SLIP_THRESH:   cfg.slip_threshold <= cfg_data[wsl_pkg::SLIP_W-1:0];
        wsl_pkg::CFG_MIN_GPS_SPEED: cfg.min_gps_speed <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/wsl_div.sv @@
module wsl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  wsl_pkg::div_req_t           req,
  output logic                        done,
  output logic [wsl_pkg::RPM_W-1:0]   quotient
);

  logic                          busy;
  logic [wsl_pkg::STEP_W-1:0]    cnt;
  logic [wsl_pkg::RPM_W-1:0]     rem;
  logic [wsl_pkg::RPM_W-1:0]     dsh;
  logic [wsl_pkg::RPM_W-1:0]     dvs;
  logic [wsl_pkg::RPM_W-1:0]     quo;
  logic [wsl_pkg::RPM_W:0]       trial;
  logic [wsl_pkg::RPM_W:0]       diff;
  logic                          ge;

  always_comb begin
    trial = {rem, dsh[wsl_pkg::RPM_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == wsl_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dsh <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[wsl_pkg::RPM_W-1:0] : trial[wsl_pkg::RPM_W-1:0];
      dsh <= {dsh[wsl_pkg::RPM_W-2:0], 1'b0};
      quo <= {quo[wsl_pkg::RPM_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/wheel_slip_traction_limiter.sv @@
// Wheel slip traction limiter.
// Input channel (in_valid/in_stall) carries one sample: engine, drive-wheel and
// reference-wheel RPM, GPS fix, ground speed and GPS-equivalent RPM. Output channel
// (out_valid/out_stall) returns one result per sample: main_drive, second_drive,
// slip_percent (Q7.8) and speed_ratio (Q8.8, saturating).
// Configuration is a write-only port (cfg_write, cfg_index, cfg_data); write it
// only while no sample is in flight.
// Per sample, one shared 16x16 multiplier makes a pass each for the wheel speed
// and the slip numerator, then a one-bit-per-cycle restoring divider runs 15 steps
// for slip and 16 for the ratio. A divider run is skipped when slip is zero or
// held, and when the ratio is zero or saturates. in_stall stays high while a
// sample is in work, so a new sample is taken only once the sequencer is idle.
// Results sit in an output register; the next sample is taken while a result
// waits. If the previous result is still stalled when a new one is ready, the
// sequencer holds until the output register frees.
// Synchronous reset clears configuration, held vehicle RPM and held slip, and
// empties the output register.
module wheel_slip_traction_limiter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [wsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wsl_pkg::RPM_W-1:0]         engine_rpm,
  input  logic [wsl_pkg::RPM_W-1:0]         drive_wheel_rpm,
  input  logic [wsl_pkg::RPM_W-1:0]         reference_wheel_rpm,
  input  logic                              gps_has_fix,
  input  logic [wsl_pkg::RPM_W-1:0]         ground_speed,
  input  logic [wsl_pkg::RPM_W-1:0]         gps_equivalent_rpm,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              main_drive,
  output logic                              second_drive,
  output logic [wsl_pkg::SLIP_W-1:0]        slip_percent,
  output logic [wsl_pkg::RPM_W-1:0]         speed_ratio
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_SPEED      = 8'b0000_0010,
    S_SLIP_MUL   = 8'b0000_0100,
    S_SLIP_DIV   = 8'b0000_1000,
    S_SLIP_WAIT  = 8'b0001_0000,
    S_RATIO      = 8'b0010_0000,
    S_RATIO_WAIT = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  wsl_pkg::cfg_t     cfg;
  wsl_pkg::div_req_t div_req;
  logic              div_done;
  logic [wsl_pkg::RPM_W-1:0] div_quo;

  logic [wsl_pkg::RPM_W-1:0]  tire;
  logic [wsl_pkg::RPM_W-1:0]  refw;
  logic [wsl_pkg::RPM_W-1:0]  gspeed;
  logic                       fix;
  logic                       upd;
  logic                       second;
  logic [wsl_pkg::RPM_W-1:0]  held_veh;
  logic [wsl_pkg::SLIP_W-1:0] held_slip;
  logic [wsl_pkg::RPM_W-1:0]  ratio;
  logic [wsl_pkg::PROD_W-1:0] prod;

  logic                       in_xfer;
  logic                       out_load;
  logic                       main_on;
  logic [wsl_pkg::RPM_W-1:0]  in_tire;
  logic [wsl_pkg::RPM_W-1:0]  mul_a;
  logic [wsl_pkg::RPM_W-1:0]  mul_b;
  logic [26:0]                thr_scaled;
  logic                       veh_lt_tire;
  logic                       ratio_sat;

  wsl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wsl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    in_tire     = (engine_rpm > drive_wheel_rpm) ? engine_rpm : drive_wheel_rpm;
    veh_lt_tire = held_veh < tire;
    ratio_sat   = {8'b0, tire} >= {held_veh, 8'b0};
    thr_scaled  = ({11'b0, cfg.second_speed_threshold} << 10) +
                  ({11'b0, cfg.second_speed_threshold} << 5);
    main_on     = upd && (held_slip > cfg.slip_threshold) &&
                  !(gspeed < cfg.min_gps_speed);
    if (state == S_SPEED) begin
      mul_a = cfg.tire_circumference;
      mul_b = refw;
    end else begin
      mul_a = wsl_pkg::SLIP_SCALE;
      mul_b = tire - held_veh;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    case (state)
      S_IDLE:      if (in_xfer) state_next = S_SPEED;
      S_SPEED:     state_next = S_SLIP_MUL;
      S_SLIP_MUL:  state_next = (upd && veh_lt_tire) ? S_SLIP_DIV : S_RATIO;
      S_SLIP_DIV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = prod[30:15];
        div_req.dividend = {prod[14:0], 1'b0};
        div_req.divisor  = tire;
        div_req.steps    = wsl_pkg::STEP_W'(wsl_pkg::SLIP_W);
        state_next       = S_SLIP_WAIT;
      end
      S_SLIP_WAIT: if (div_done) state_next = S_RATIO;
      S_RATIO: begin
        if (held_veh == '0 || ratio_sat) begin
          state_next = S_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = {8'b0, tire[15:8]};
          div_req.dividend = {tire[7:0], 8'b0};
          div_req.divisor  = held_veh;
          div_req.steps    = wsl_pkg::STEP_W'(wsl_pkg::RPM_W);
          state_next       = S_RATIO_WAIT;
        end
      end
      S_RATIO_WAIT: if (div_done) state_next = S_FINISH;
      S_FINISH:    if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held_veh  <= '0;
      held_slip <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        if (!cfg.gps_mode) begin
          held_veh <= (reference_wheel_rpm > cfg.min_vehicle_rpm) ?
                      reference_wheel_rpm : cfg.min_vehicle_rpm;
        end else if (gps_has_fix) begin
          held_veh <= gps_equivalent_rpm;
        end
      end
      if (state == S_SLIP_MUL && upd && !veh_lt_tire) held_slip <= '0;
      if (state == S_SLIP_WAIT && div_done) held_slip <= div_quo[wsl_pkg::SLIP_W-1:0];
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tire   <= in_tire;
      refw   <= reference_wheel_rpm;
      gspeed <= ground_speed;
      fix    <= gps_has_fix;
      upd    <= !cfg.gps_mode || gps_has_fix;
    end
    if (state == S_SPEED || state == S_SLIP_MUL) begin
      prod <= wsl_pkg::PROD_W'(mul_a) * wsl_pkg::PROD_W'(mul_b);
    end
    if (state == S_SLIP_MUL) begin
      second <= cfg.gps_mode ? (fix && (gspeed < cfg.second_speed_threshold)) :
                               (prod < {5'b0, thr_scaled});
    end
    if (state == S_RATIO) ratio <= (held_veh == '0) ? '0 : '1;
    if (state == S_RATIO_WAIT && div_done) ratio <= div_quo;
    if (out_load) begin
      main_drive   <= main_on;
      second_drive <= second;
      slip_percent <= held_slip;
      speed_ratio  <= ratio;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_SPEED)
    else $error("accepted sample did not start the sequence");

  a_slip_range: assert property (@(posedge clk) disable iff (rst)
    held_slip <= wsl_pkg::SLIP_SCALE[wsl_pkg::SLIP_W-1:0])
    else $error("held slip out of range");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_SLIP_WAIT || state == S_RATIO_WAIT))
    else $error("divider finished with no one waiting");

  a_zero_vehicle_ratio: assert property (@(posedge clk) disable iff (rst)
    (out_load && held_veh == '0) |=> speed_ratio == '0)
    else $error("nonzero ratio for zero vehicle RPM");

endmodule

@@ test/wheel_slip_traction_limiter_test.sv @@
`timescale 1ns / 1ps

module wheel_slip_traction_limiter_test;

  localparam int unsigned RPM_W            = wsl_pkg::RPM_W;
  localparam int unsigned SLIP_W           = wsl_pkg::SLIP_W;
  localparam int unsigned CFG_IDX_W        = wsl_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W       = wsl_pkg::CFG_DATA_W;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS      = 230;
  localparam int unsigned INCH_RPM_PER_MPH = 1056;
  localparam logic [RPM_W-1:0] RPM_MAX     = '1;

  typedef struct packed {
    logic [RPM_W-1:0] engine_rpm;
    logic [RPM_W-1:0] drive_wheel_rpm;
    logic [RPM_W-1:0] reference_wheel_rpm;
    logic             gps_has_fix;
    logic [RPM_W-1:0] ground_speed;
    logic [RPM_W-1:0] gps_equivalent_rpm;
  } sample_t;

  typedef struct packed {
    logic              main_drive;
    logic              second_drive;
    logic [SLIP_W-1:0] slip_percent;
    logic [RPM_W-1:0]  speed_ratio;
  } drive_t;

  class traction_model;
    wsl_pkg::cfg_t     regs;
    logic [RPM_W-1:0]  held_vehicle;
    logic [SLIP_W-1:0] held_slip_pct;
    drive_t            due[$];
    int                mismatches;

    function new();
      regs = '0;
      held_vehicle = '0;
      held_slip_pct = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (wsl_pkg::cfg_idx_t'(idx))
        wsl_pkg::CFG_GPS_MODE:      regs.gps_mode = data[0];
        wsl_pkg::CFG_TIRE_CIRC:     regs.tire_circumference = data;
        wsl_pkg::CFG_SECOND_THRESH: regs.second_speed_threshold = data;
        wsl_pkg::CFG_MIN_VEH_RPM:   regs.min_vehicle_rpm = data;
        wsl_pkg::CFG_SLIP_THRESH:   regs.slip_threshold = data[SLIP_W-1:0];
        wsl_pkg::CFG_MIN_GPS_SPEED: regs.min_gps_speed = data;
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      logic [RPM_W-1:0] tire;
      logic [32:0]      wheel_speed_x;
      logic [32:0]      threshold_x;
      logic [39:0]      slip_num;
      logic [31:0]      quot;
      logic             refresh;
      drive_t           r;
      tire = (s.engine_rpm > s.drive_wheel_rpm) ? s.engine_rpm : s.drive_wheel_rpm;
      refresh = 1'b1;
      if (regs.gps_mode) begin
        r.second_drive = s.gps_has_fix && (s.ground_speed < regs.second_speed_threshold);
        if (s.gps_has_fix) held_vehicle = s.gps_equivalent_rpm;
        else refresh = 1'b0;
      end else begin
        wheel_speed_x = 33'(regs.tire_circumference) * 33'(s.reference_wheel_rpm);
        threshold_x = 33'(regs.second_speed_threshold) * 33'(INCH_RPM_PER_MPH);
        r.second_drive = wheel_speed_x < threshold_x;
        held_vehicle = (s.reference_wheel_rpm > regs.min_vehicle_rpm) ?
                       s.reference_wheel_rpm : regs.min_vehicle_rpm;
      end
      r.main_drive = 1'b0;
      if (refresh) begin
        if (held_vehicle < tire) begin
          slip_num = 40'(wsl_pkg::SLIP_SCALE) * 40'(tire - held_vehicle);
          slip_num = slip_num / 40'(tire);
          held_slip_pct = slip_num[SLIP_W-1:0];
        end else begin
          held_slip_pct = '0;
        end
        r.main_drive = (held_slip_pct > regs.slip_threshold) &&
                       (s.ground_speed >= regs.min_gps_speed);
      end
      r.slip_percent = held_slip_pct;
      if (held_vehicle == '0) begin
        r.speed_ratio = '0;
      end else begin
        quot = {8'd0, tire, 8'd0} / {16'd0, held_vehicle};
        r.speed_ratio = (quot > {16'd0, RPM_MAX}) ? RPM_MAX : quot[RPM_W-1:0];
      end
      due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      if (due.size() == 0) begin
        $error("result transfer with no sample outstanding");
        mismatches++;
        return;
      end
      want = due.pop_front();
      compare_field("main_drive", 32'(want.main_drive), 32'(got.main_drive));
      compare_field("second_drive", 32'(want.second_drive), 32'(got.second_drive));
      compare_field("slip_percent", 32'(want.slip_percent), 32'(got.slip_percent));
      compare_field("speed_ratio", 32'(want.speed_ratio), 32'(got.speed_ratio));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [RPM_W-1:0]      engine_rpm;
  logic [RPM_W-1:0]      drive_wheel_rpm;
  logic [RPM_W-1:0]      reference_wheel_rpm;
  logic                  gps_has_fix;
  logic [RPM_W-1:0]      ground_speed;
  logic [RPM_W-1:0]      gps_equivalent_rpm;
  logic                  out_valid;
  logic                  out_stall;
  logic                  main_drive;
  logic                  second_drive;
  logic [SLIP_W-1:0]     slip_percent;
  logic [RPM_W-1:0]      speed_ratio;

  traction_model model;
  bit            steady;
  bit            hold_armed;
  int            hold_cnt;
  int            stuck;

  wheel_slip_traction_limiter uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .engine_rpm          (engine_rpm),
    .drive_wheel_rpm     (drive_wheel_rpm),
    .reference_wheel_rpm (reference_wheel_rpm),
    .gps_has_fix         (gps_has_fix),
    .ground_speed        (ground_speed),
    .gps_equivalent_rpm  (gps_equivalent_rpm),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .main_drive          (main_drive),
    .second_drive        (second_drive),
    .slip_percent        (slip_percent),
    .speed_ratio         (speed_ratio)
  );

  always #5 clk = ~clk;

  // result side: random stalls, occasional long stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_armed) begin
      hold_armed = 1'b0;
      out_stall <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(99) < 2) begin
      out_stall <= 1'b1;
      hold_cnt <= $urandom_range(60, 1);
    end else begin
      out_stall <= ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      model.check_result(drive_t'{main_drive, second_drive, slip_percent, speed_ratio});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic send_sample(sample_t s);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      if ($urandom_range(99) < 5) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(60, 1)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    engine_rpm <= s.engine_rpm;
    drive_wheel_rpm <= s.drive_wheel_rpm;
    reference_wheel_rpm <= s.reference_wheel_rpm;
    gps_has_fix <= s.gps_has_fix;
    ground_speed <= s.ground_speed;
    gps_equivalent_rpm <= s.gps_equivalent_rpm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.note_sample(s);
  endtask

  // writes every index, the unused ones too; spare data bits are random
  task automatic load_settings(wsl_pkg::cfg_t c);
    logic [CFG_DATA_W-1:0] data;
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      data = CFG_DATA_W'($urandom_range(RPM_MAX));
      case (wsl_pkg::cfg_idx_t'(i[CFG_IDX_W-1:0]))
        wsl_pkg::CFG_GPS_MODE:      data[0] = c.gps_mode;
        wsl_pkg::CFG_TIRE_CIRC:     data = c.tire_circumference;
        wsl_pkg::CFG_SECOND_THRESH: data = c.second_speed_threshold;
        wsl_pkg::CFG_MIN_VEH_RPM:   data = c.min_vehicle_rpm;
        wsl_pkg::CFG_SLIP_THRESH:   data[SLIP_W-1:0] = c.slip_threshold;
        wsl_pkg::CFG_MIN_GPS_SPEED: data = c.min_gps_speed;
        default: ;
      endcase
      cfg_write <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= data;
      @(posedge clk);
      model.write_reg(i[CFG_IDX_W-1:0], data);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(wsl_pkg::cfg_t c, sample_t items[$], bit squeeze);
    while (model.due.size() != 0) @(posedge clk);
    load_settings(c);
    if (squeeze) hold_armed = 1'b1;
    foreach (items[k]) send_sample(items[k]);
    in_valid <= 1'b0;
  endtask

  function automatic logic [RPM_W-1:0] rand_rpm();
    case ($urandom_range(9))
      0: return '0;
      1: return RPM_MAX;
      2: return RPM_W'($urandom_range(300));
      default: return RPM_W'($urandom_range(RPM_MAX));
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t          s;
    logic [RPM_W-1:0] tire;
    s.engine_rpm = rand_rpm();
    s.drive_wheel_rpm = $urandom_range(1) ? rand_rpm()
                                          : RPM_W'(s.engine_rpm - $urandom_range(50));
    tire = (s.engine_rpm > s.drive_wheel_rpm) ? s.engine_rpm : s.drive_wheel_rpm;
    // mostly a vehicle speed a little under the tire speed, so slip lands near thresholds
    s.reference_wheel_rpm = ($urandom_range(9) < 6) ?
                            RPM_W'(tire - $urandom_range(tire >> 2)) : rand_rpm();
    s.gps_equivalent_rpm = ($urandom_range(9) < 6) ?
                           RPM_W'(tire - $urandom_range(tire >> 2)) : rand_rpm();
    s.gps_has_fix = ($urandom_range(99) < 75);
    s.ground_speed = ($urandom_range(9) < 2) ? rand_rpm()
                                             : RPM_W'($urandom_range(16'h6000));
    return s;
  endfunction

  function automatic wsl_pkg::cfg_t rand_settings(bit mode);
    wsl_pkg::cfg_t c;
    c.gps_mode = mode;
    c.tire_circumference = ($urandom_range(4) == 0) ? rand_rpm()
                           : RPM_W'($urandom_range(16'h7000, 16'h4000));
    c.second_speed_threshold = ($urandom_range(4) == 0) ? rand_rpm()
                               : RPM_W'($urandom_range(16'h4000));
    c.min_vehicle_rpm = ($urandom_range(4) == 0) ? rand_rpm()
                        : RPM_W'($urandom_range(2000));
    case ($urandom_range(7))
      0: c.slip_threshold = '0;
      1: c.slip_threshold = wsl_pkg::SLIP_SCALE[SLIP_W-1:0];
      2: c.slip_threshold = '1;
      default: c.slip_threshold = SLIP_W'($urandom_range(wsl_pkg::SLIP_SCALE));
    endcase
    c.min_gps_speed = ($urandom_range(4) == 0) ? rand_rpm()
                      : RPM_W'($urandom_range(16'h0800));
    return c;
  endfunction

  initial begin
    sample_t plan[$];
    model = new();
    clk = 1'b0;
    rst = 1'b1;
    steady = 1'b0;
    hold_armed = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    engine_rpm = '0;
    drive_wheel_rpm = '0;
    reference_wheel_rpm = '0;
    gps_has_fix = 1'b0;
    ground_speed = '0;
    gps_equivalent_rpm = '0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings, all fields at both extremes
    plan = '{sample_t'{16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
             sample_t'{RPM_MAX, RPM_MAX, RPM_MAX, 1'b1, RPM_MAX, RPM_MAX}};
    foreach (plan[k]) send_sample(plan[k]);
    in_valid <= 1'b0;

    // wheel mode: floor, ratio saturation, low GPS speed cut, no slip
    plan = '{sample_t'{16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
             sample_t'{RPM_MAX, 16'd1, 16'd1, 1'b1, RPM_MAX, 16'h0},
             sample_t'{16'd1000, 16'd2000, 16'd1500, 1'b1, 16'h0100, 16'h0},
             sample_t'{16'd1000, 16'd2000, 16'd1500, 1'b0, 16'h3000, 16'h0},
             sample_t'{16'd3000, 16'd0, 16'd3000, 1'b0, RPM_MAX, RPM_MAX},
             sample_t'{16'd0, 16'd0, RPM_MAX, 1'b1, 16'h2000, 16'h0}};
    run_phase(wsl_pkg::cfg_t'{1'b0, 16'h5800, 16'h1400, 16'd100, 15'd2560, 16'h0200},
              plan, 1'b0);

    // GPS mode: zero vehicle speed, low speed cut, lost fix holds state
    plan = '{sample_t'{16'd1000, 16'd0, 16'd0, 1'b1, 16'h0800, 16'd0},
             sample_t'{16'd1000, 16'd1200, 16'd0, 1'b1, 16'h0400, 16'd600},
             sample_t'{16'd4000, 16'd0, 16'd0, 1'b0, 16'h0800, 16'd123},
             sample_t'{16'd0, 16'd0, RPM_MAX, 1'b0, 16'h0, RPM_MAX},
             sample_t'{16'd500, 16'd400, 16'd0, 1'b1, RPM_MAX, 16'd900},
             sample_t'{RPM_MAX, RPM_MAX, 16'd0, 1'b1, 16'h0FFF, 16'd1}};
    run_phase(wsl_pkg::cfg_t'{1'b1, 16'h0, 16'h1000, RPM_MAX, 15'd0, 16'h0500},
              plan, 1'b0);

    // every register but the GPS mode bit at its top value
    plan = '{sample_t'{RPM_MAX, 16'd0, RPM_MAX, 1'b1, RPM_MAX, 16'd0},
             sample_t'{16'd1, 16'd0, 16'd0, 1'b1, RPM_MAX, RPM_MAX},
             sample_t'{RPM_MAX, RPM_MAX, 16'd0, 1'b0, 16'h0, 16'h0}};
    run_phase(wsl_pkg::cfg_t'{1'b0, RPM_MAX, RPM_MAX, RPM_MAX, 15'h7FFF, RPM_MAX},
              plan, 1'b0);

    // full slip equal to the threshold does not cut
    plan = '{sample_t'{RPM_MAX, 16'd0, 16'd0, 1'b1, 16'h0, 16'h0}};
    run_phase(wsl_pkg::cfg_t'{1'b1, 16'h0, 16'h0, 16'h0,
                              wsl_pkg::SLIP_SCALE[SLIP_W-1:0], 16'h0}, plan, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      plan.delete();
      repeat (PHASE_ITEMS) plan.push_back(rand_sample());
      steady = (p == 3);
      run_phase(rand_settings(p[0]), plan, p == 5);
    end
    steady = 1'b0;

    while (model.due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (model.mismatches == 0 && model.due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
